### rtl/core/jdht_pkg.sv
// shared constants and types for the jpeg dht canonical code builder
`timescale 1ns / 1ps
`default_nettype none

package jdht_pkg;

  localparam int unsigned MAX_CODE_LENGTH_DEF = 16;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned NEXT_W  = 17;
  localparam int unsigned SYMCNT_W = 12;

  typedef struct packed {
    logic              hit;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] count;
  } len_sel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              overflow;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/jdht_count_store.sv
// code count table with search for the next used code length
`timescale 1ns / 1ps
`default_nettype none

module jdht_count_store #(
  parameter int unsigned MaxCodeLength = jdht_pkg::MAX_CODE_LENGTH_DEF,
  localparam int unsigned IdxW = (MaxCodeLength > 1) ? $clog2(MaxCodeLength) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [IdxW-1:0]             wr_idx_i,
  input  wire logic [jdht_pkg::BYTE_W-1:0] wr_data_i,
  input  wire logic [jdht_pkg::LEN_W-1:0]  cur_len_i,
  output jdht_pkg::len_sel_t               sel_o
);

  logic [jdht_pkg::BYTE_W-1:0] count_q [MaxCodeLength];
  logic [IdxW-1:0]             sel_idx;
  logic                        hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      count_q[wr_idx_i] <= wr_data_i;
    end
  end

  // lowest used length strictly above the current one
  always_comb begin
    hit     = 1'b0;
    sel_idx = '0;
    for (int i = MaxCodeLength - 1; i >= 0; i--) begin
      if ((count_q[i] != '0) && (jdht_pkg::LEN_W'(i) >= cur_len_i)) begin
        hit     = 1'b1;
        sel_idx = IdxW'(i);
      end
    end
  end

  always_comb begin
    sel_o.hit   = hit;
    sel_o.len   = jdht_pkg::LEN_W'(sel_idx) + jdht_pkg::LEN_W'(1);
    sel_o.count = count_q[sel_idx];
  end

endmodule

`default_nettype wire

### rtl/core/jdht_code_gen.sv
// table parser state and canonical code assignment for one word
`timescale 1ns / 1ps
`default_nettype none

module jdht_code_gen #(
  parameter int unsigned MaxCodeLength = jdht_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        fire_i,
  input  wire logic [jdht_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                        start_i,
  output logic                             res_valid_o,
  output jdht_pkg::result_t                res_o
);

  localparam int unsigned IdxW = (MaxCodeLength > 1) ? $clog2(MaxCodeLength) : 1;
  localparam int unsigned BiW  = $clog2(MaxCodeLength + 1);

  logic [BiW-1:0]                byte_index_q, byte_index_d, bi_e;
  logic [jdht_pkg::LEN_W-1:0]    cur_len_q, cur_len_d, cl_e, cl_n;
  logic [jdht_pkg::BYTE_W-1:0]   left_q, left_d, left_e, left_n;
  logic [jdht_pkg::NEXT_W-1:0]   next_q, next_d, nc_e, nc_n;
  logic [jdht_pkg::SYMCNT_W-1:0] syms_q, syms_d, sl_e;
  logic [jdht_pkg::LEN_W-1:0]    shamt;
  logic                          count_phase, overflow;
  jdht_pkg::len_sel_t            sel;

  always_comb begin
    if (start_i) begin
      bi_e   = '0;
      cl_e   = '0;
      left_e = '0;
      nc_e   = '0;
      sl_e   = '0;
    end else begin
      bi_e   = byte_index_q;
      cl_e   = cur_len_q;
      left_e = left_q;
      nc_e   = next_q;
      sl_e   = syms_q;
    end
  end

  assign count_phase = bi_e < BiW'(MaxCodeLength);

  jdht_count_store #(
    .MaxCodeLength(MaxCodeLength)
  ) u_count_store (
    .clk_i     (clk_i),
    .wr_en_i   (fire_i && count_phase),
    .wr_idx_i  (bi_e[IdxW-1:0]),
    .wr_data_i (byte_i),
    .cur_len_i (cl_e),
    .sel_o     (sel)
  );

  // step to the next used length, doubling the code per length
  always_comb begin
    cl_n   = cl_e;
    left_n = left_e;
    shamt  = '0;
    if (left_e == '0) begin
      if (sel.hit) begin
        cl_n   = sel.len;
        left_n = sel.count;
      end else begin
        cl_n   = jdht_pkg::LEN_W'(MaxCodeLength);
        left_n = '0;
      end
      shamt = cl_n - cl_e;
    end
    nc_n = nc_e << shamt;
  end

  assign overflow = (nc_n >> cl_n) != '0;

  always_comb begin
    byte_index_d = bi_e;
    cur_len_d    = cl_e;
    left_d       = left_e;
    next_d       = nc_e;
    syms_d       = sl_e;
    res_valid_o  = 1'b0;
    if (count_phase) begin
      byte_index_d = bi_e + BiW'(1);
      syms_d       = sl_e + jdht_pkg::SYMCNT_W'(byte_i);
    end else if (sl_e != '0) begin
      cur_len_d = cl_n;
      left_d    = left_n;
      next_d    = nc_n;
      if (left_n != '0) begin
        res_valid_o = 1'b1;
        left_d      = left_n - jdht_pkg::BYTE_W'(1);
        syms_d      = sl_e - jdht_pkg::SYMCNT_W'(1);
        if (!overflow) begin
          next_d = nc_n + jdht_pkg::NEXT_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_o.symbol   = byte_i;
    res_o.code     = overflow ? '0 : nc_n[jdht_pkg::CODE_W-1:0];
    res_o.len      = cl_n;
    res_o.overflow = overflow;
    res_o.last     = (syms_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      cur_len_q    <= '0;
      left_q       <= '0;
      next_q       <= '0;
      syms_q       <= '0;
    end else if (fire_i) begin
      byte_index_q <= byte_index_d;
      cur_len_q    <= cur_len_d;
      left_q       <= left_d;
      next_q       <= next_d;
      syms_q       <= syms_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jpeg_dht_canonical_code_builder.sv
// Canonical Huffman code builder for the body of a JPEG DHT segment. Bytes enter one word
// per cycle unless the output stalls: the first MaxCodeLength words are code counts per
// length, the words after them are symbols, and each symbol word yields one result word
// with its canonical code, length, an overflow flag (no free code left at that length, code
// reads 0) and a last-symbol flag. Count words and words past the end of the table yield
// nothing; start_of_table_i restarts the parser. A word is held in the input word register,
// then its result in the result word register. The code stage updates the parser state for
// each word, where a priority encoder over the count table finds the next used length.
`timescale 1ns / 1ps
`default_nettype none

module jpeg_dht_canonical_code_builder #(
  parameter int unsigned MaxCodeLength = jdht_pkg::MAX_CODE_LENGTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [jdht_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                          start_of_table_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [jdht_pkg::BYTE_W-1:0]        symbol_value_o,
  output logic [jdht_pkg::CODE_W-1:0]        code_word_o,
  output logic [jdht_pkg::LEN_W-1:0]         code_length_o,
  output logic                               overflow_error_o,
  output logic                               last_symbol_o
);

  logic                        in_valid_q;
  logic [jdht_pkg::BYTE_W-1:0] in_byte_q;
  logic                        in_start_q;
  logic                        advance, fire, res_valid;
  jdht_pkg::result_t           res, out_q;
  logic                        out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_of_table_i;
    end
  end

  jdht_code_gen #(
    .MaxCodeLength(MaxCodeLength)
  ) u_code_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .start_i     (in_start_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_value_o   = out_q.symbol;
  assign code_word_o      = out_q.code;
  assign code_length_o    = out_q.len;
  assign overflow_error_o = out_q.overflow;
  assign last_symbol_o    = out_q.last;

  a_ovf_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_error_o |-> code_word_o == '0)
    else $error("overflowed code is not zero");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (code_length_o != '0) &&
                    (code_length_o <= jdht_pkg::LEN_W'(MaxCodeLength)))
    else $error("code length out of range");

  a_code_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_error_o |-> (code_word_o >> code_length_o) == '0)
    else $error("code wider than its length");

endmodule

`default_nettype wire
